[rtl/length_prefixed_message_ring_core_macros.svh]
// assertion macros used by the checker file
`ifndef LENGTH_PREFIXED_MESSAGE_RING_CORE_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define LPMR_ASSERT_NOW(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("%m: check failed");

// property that must hold in the cycle after its trigger
`define LPMR_ASSERT_NEXT(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("%m: check failed");

`endif

[rtl/lpmr_pkg.sv]
// shared types, codes and defaults for the message ring
package lpmr_pkg;

  localparam int DEPTH_WORDS_DEF = 1024;
  localparam int ALIGN_WORDS_DEF = 2;
  localparam int CW = 11;

  localparam logic [2:0] CMD_WRITE_START = 3'd0;
  localparam logic [2:0] CMD_WRITE_WORD  = 3'd1;
  localparam logic [2:0] CMD_READ_START  = 3'd2;
  localparam logic [2:0] CMD_READ_WORD   = 3'd3;
  localparam logic [2:0] CMD_CLEAR       = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ROOM   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_SMALL = 3'd3;
  localparam logic [2:0] ST_NOT_OPEN  = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] msg_bytes;
    logic [31:0] wdata;
    logic [11:0] reader_room;
  } req_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [11:0]   length_out;
    logic [31:0]   rdata;
    logic          last;
    logic [CW-1:0] free_words;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic exec;
  } ctrl_t;

endpackage

[rtl/lpmr_ctrl.sv]
// command sequencer: accept, execute, result strobe
module lpmr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output lpmr_pkg::ctrl_t ctrl
);
  import lpmr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign busy        = (state == S_EXEC);
  assign ctrl.accept = start && (state == S_IDLE);
  assign ctrl.exec   = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.exec;
    end
  end
endmodule

[rtl/lpmr_dp.sv]
// ring memory, pointers, counters and result register
module lpmr_dp #(
  parameter int DEPTH_WORDS = lpmr_pkg::DEPTH_WORDS_DEF,
  parameter int ALIGN_WORDS = lpmr_pkg::ALIGN_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpmr_pkg::ctrl_t       ctrl,
  input  lpmr_pkg::req_t        req,
  input  logic                  cfg_we,
  input  logic [lpmr_pkg::CW-1:0] cfg_wdata,
  output lpmr_pkg::rsp_t        rsp
);
  import lpmr_pkg::*;

  localparam int AW = $clog2(DEPTH_WORDS);
  localparam int SW = ((AW > CW) ? AW : CW) + 1;
  localparam int RSH = 20;
  localparam int RECIP = ((1 << RSH) + ALIGN_WORDS - 1) / ALIGN_WORDS;
  localparam int CAP_SAT = (DEPTH_WORDS < 1024) ? DEPTH_WORDS : 1024;
  localparam int CAP_RND = CAP_SAT - (CAP_SAT % ALIGN_WORDS);
  localparam int CAP_RESET = (CAP_RND < ALIGN_WORDS) ? ALIGN_WORDS : CAP_RND;

  // exact x / ALIGN_WORDS for 11-bit x by reciprocal multiply
  function automatic logic [CW-1:0] div_align(input logic [CW-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP);
    return CW'(p >> RSH);
  endfunction

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off,
                                         input logic [CW-1:0] cap);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(cap)) s = s - SW'(cap);
    return AW'(s);
  endfunction

  logic [31:0] mem [DEPTH_WORDS];
  logic [31:0] mem_q;

  logic [CW-1:0] capacity, used_words, write_words_left, write_total_words;
  logic [CW-1:0] read_words_left, wr_offset, rd_offset, rd_total, rd_payload;
  logic [AW-1:0] read_head, write_head;
  req_t          req_q;

  logic [CW-1:0] used_words_next, write_words_left_next, write_total_words_next;
  logic [CW-1:0] read_words_left_next, wr_offset_next, rd_offset_next;
  logic [CW-1:0] rd_total_next, rd_payload_next;
  logic [AW-1:0] read_head_next, write_head_next;
  rsp_t          rsp_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  // write start sizing
  logic [12:0]   bytes_p3;
  logic [CW-1:0] pw, total;
  logic [12:0]   len_full;
  // read start header
  logic [15:0]   pbytes;
  logic [CW-1:0] hdr_total;
  // capacity decode
  logic [31:0]   cap_sat;
  logic [CW-1:0] cap_rnd;

  assign bytes_p3 = 13'(req_q.msg_bytes) + 13'd3;
  assign pw       = CW'(bytes_p3[12:2]);
  assign total    = CW'(32'(div_align(pw + CW'(ALIGN_WORDS))) * 32'(ALIGN_WORDS));
  assign len_full = {total - CW'(1), 2'b00};
  assign pbytes   = mem_q[15:0];
  assign hdr_total = CW'(pbytes[12:2]) + CW'(1);

  assign cap_sat = (32'(cfg_wdata) > 32'(DEPTH_WORDS)) ? 32'(DEPTH_WORDS) : 32'(cfg_wdata);
  assign cap_rnd = CW'(32'(div_align(CW'(cap_sat))) * 32'(ALIGN_WORDS));

  assign mem_raddr = (req.command == CMD_READ_START) ? read_head
                                                     : wrap(read_head, rd_offset, capacity);

  always_comb begin
    used_words_next        = used_words;
    write_words_left_next  = write_words_left;
    write_total_words_next = write_total_words;
    read_words_left_next   = read_words_left;
    wr_offset_next         = wr_offset;
    rd_offset_next         = rd_offset;
    rd_total_next          = rd_total;
    rd_payload_next        = rd_payload;
    read_head_next         = read_head;
    write_head_next        = write_head;
    mem_we                 = 1'b0;
    mem_waddr              = write_head;
    mem_wdata              = '0;
    rsp_next               = '0;
    rsp_next.status        = ST_OK;

    case (req_q.command)
      CMD_WRITE_START: begin
        write_words_left_next = '0;
        rsp_next.length_out   = len_full[11:0];
        if (capacity - used_words >= total) begin
          mem_we                 = 1'b1;
          mem_waddr              = write_head;
          mem_wdata              = {5'b0, pw, 16'(len_full)};
          write_total_words_next = total;
          write_words_left_next  = pw;
          wr_offset_next         = CW'(1);
          if (pw == '0) begin
            used_words_next       = used_words + total;
            write_head_next       = wrap(write_head, total, capacity);
            write_words_left_next = '0;
          end
        end else begin
          rsp_next.status = ST_NO_ROOM;
        end
      end
      CMD_WRITE_WORD: begin
        if (write_words_left == '0) begin
          rsp_next.status = ST_NOT_OPEN;
        end else begin
          mem_we                = 1'b1;
          mem_waddr             = wrap(write_head, wr_offset, capacity);
          mem_wdata             = req_q.wdata;
          wr_offset_next        = wr_offset + CW'(1);
          write_words_left_next = write_words_left - CW'(1);
          if (write_words_left == CW'(1)) begin
            used_words_next = used_words + write_total_words;
            write_head_next = wrap(write_head, write_total_words, capacity);
          end
        end
      end
      CMD_READ_START: begin
        read_words_left_next = '0;
        if (used_words == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.length_out = pbytes[11:0];
          if (pbytes > 16'(req_q.reader_room)) begin
            rsp_next.status = ST_TOO_SMALL;
          end else begin
            rd_total_next        = hdr_total;
            rd_payload_next      = mem_q[16+CW-1:16];
            rd_offset_next       = CW'(1);
            read_words_left_next = hdr_total - CW'(1);
            if (hdr_total == CW'(1)) begin
              used_words_next = used_words - hdr_total;
              read_head_next  = wrap(read_head, hdr_total, capacity);
            end
          end
        end
      end
      CMD_READ_WORD: begin
        if (read_words_left == '0) begin
          rsp_next.status = ST_NOT_OPEN;
        end else begin
          if (rd_offset <= rd_payload) rsp_next.rdata = mem_q;
          rd_offset_next       = rd_offset + CW'(1);
          read_words_left_next = read_words_left - CW'(1);
          if (read_words_left == CW'(1)) begin
            rsp_next.last   = 1'b1;
            used_words_next = used_words - rd_total;
            read_head_next  = wrap(read_head, rd_total, capacity);
          end
        end
      end
      CMD_CLEAR: begin
        used_words_next        = '0;
        write_words_left_next  = '0;
        write_total_words_next = '0;
        read_words_left_next   = '0;
        wr_offset_next         = '0;
        rd_offset_next         = '0;
        rd_total_next          = '0;
        rd_payload_next        = '0;
        read_head_next         = '0;
        write_head_next        = '0;
      end
      default: ;
    endcase
    rsp_next.free_words = capacity - used_words_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && mem_we) mem[mem_waddr] <= mem_wdata;
    if (ctrl.accept) begin
      mem_q <= mem[mem_raddr];
      req_q <= req;
    end
    if (ctrl.exec) rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) capacity <= CW'(CAP_RESET);
      else capacity <= (cap_rnd < CW'(ALIGN_WORDS)) ? CW'(ALIGN_WORDS) : cap_rnd;
      used_words        <= '0;
      write_words_left  <= '0;
      write_total_words <= '0;
      read_words_left   <= '0;
      wr_offset         <= '0;
      rd_offset         <= '0;
      rd_total          <= '0;
      rd_payload        <= '0;
      read_head         <= '0;
      write_head        <= '0;
    end else if (ctrl.exec) begin
      used_words        <= used_words_next;
      write_words_left  <= write_words_left_next;
      write_total_words <= write_total_words_next;
      read_words_left   <= read_words_left_next;
      wr_offset         <= wr_offset_next;
      rd_offset         <= rd_offset_next;
      rd_total          <= rd_total_next;
      rd_payload        <= rd_payload_next;
      read_head         <= read_head_next;
      write_head        <= write_head_next;
    end
  end
endmodule

[rtl/length_prefixed_message_ring_core.sv]
// top level of the length-prefixed message ring
//
// a mailbox fifo for variable-length messages held in a ring of 32-bit words
// each message is a header word plus payload words, padded to the alignment
// input: an item (req) is taken at a clock edge with start high and busy low
// commands: write start, write word, read start, read word, clear
// output: one result item per input item, on rsp for exactly one cycle,
//   marked by done; the receiver cannot stall, so it must take it then
// latency: accept edge, one execute cycle (busy high), done in the cycle after
// throughput: one item every 2 cycles, set by the registered read of the ring
//   memory, which is issued at accept and used in the execute cycle
// a new start may be given while done is high
// configuration: cfg_we with cfg_wdata writes the ring capacity in words;
//   it saturates at the memory depth, rounds down to the alignment and
//   empties the ring; write it only while idle
// reset: pointers and counts cleared, capacity back to its default, no
//   open read or write; the ring memory itself is not cleared
module length_prefixed_message_ring_core #(
  parameter int DEPTH_WORDS = lpmr_pkg::DEPTH_WORDS_DEF,
  parameter int ALIGN_WORDS = lpmr_pkg::ALIGN_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  lpmr_pkg::req_t          req,
  output logic                    done,
  output lpmr_pkg::rsp_t          rsp,
  input  logic                    cfg_we,
  input  logic [lpmr_pkg::CW-1:0] cfg_wdata
);
  import lpmr_pkg::*;

  // accept and execute strobes from the sequencer
  ctrl_t ctrl;

  lpmr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .ctrl (ctrl)
  );

  // memory, pointers and result register
  lpmr_dp #(
    .DEPTH_WORDS(DEPTH_WORDS),
    .ALIGN_WORDS(ALIGN_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rsp      (rsp)
  );
endmodule

[rtl/lpmr_checker.sv]
// port-level checks for the message ring, bound to the top level
`include "length_prefixed_message_ring_core_macros.svh"

module lpmr_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input lpmr_pkg::req_t          req,
  input logic                    done,
  input lpmr_pkg::rsp_t          rsp,
  input logic                    cfg_we,
  input logic [lpmr_pkg::CW-1:0] cfg_wdata
);
  import lpmr_pkg::*;

  `LPMR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `LPMR_ASSERT_NEXT(a_accept_done, clk, rst, start && !busy, ##1 done)
  `LPMR_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `LPMR_ASSERT_NOW(a_last_ok, clk, rst, done && rsp.last, rsp.status == ST_OK)
  `LPMR_ASSERT_NOW(a_err_nodata, clk, rst, done && rsp.status != ST_OK, rsp.rdata == 32'd0)
endmodule

bind length_prefixed_message_ring_core lpmr_checker u_lpmr_checker (.*);
